// File: design/als_pkg.sv
// shared constants and types for the antialiased line stepper
`timescale 1ns / 1ps
`default_nettype none
package als_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS_DEF = 16;
	localparam int LEVEL_BITS = 8;

	localparam logic [LEVEL_BITS-1:0] FULL_LEVEL = 8'd255;
	localparam logic [LEVEL_BITS-1:0] AXIS_LEVEL = 8'd100;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	typedef struct packed {
		logic go;
		logic [COORD_BITS-1:0] num;
		logic [COORD_BITS-1:0] den;
	} div_req_t;

endpackage
`default_nettype wire

// File: design/als_divider.sv
// iterative restoring divider for the line gradient, one quotient bit a cycle
`timescale 1ns / 1ps
`default_nettype none
module als_divider #(
	parameter int FRAC_BITS = als_pkg::FRAC_BITS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  als_pkg::div_req_t      req,
	output logic                   done,
	output logic [FRAC_BITS:0]     quot
);
	import als_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int CNT_W = $clog2(FRAC_BITS + 1);
	localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(FRAC_BITS);

	logic [CW-1:0]      rem_q;
	logic [CW-1:0]      den_q;
	logic [FRAC_BITS:0] quot_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               run_q;
	logic               done_q;

	logic [CW:0] trial;
	logic [CW:0] diff;
	logic        ge;

	always_comb begin
		if (cnt_q == CNT_TOP) begin
			trial = {1'b0, rem_q};
		end else begin
			trial = {rem_q, 1'b0};
		end
		ge = (trial >= {1'b0, den_q});
		diff = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_TOP;
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= req.num;
			den_q <= req.den;
			quot_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
			quot_q <= {quot_q[FRAC_BITS-1:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

// File: design/antialiased_line_stepper_top.sv
// antialiased line stepper: command sequencer, line state and pixel output
//
// One command channel: a word is taken at a rising edge with start high and
// busy low. cmd selects start (load endpoints) or advance (one major step).
// Pixels leave on pixel_x/pixel_y/intensity/last_pixel, each for exactly one
// cycle while strobe is high; the receiver cannot stall, so none is held.
// Start: the word is ordered in S_ORDER, which also registers the first
//   endpoint pixel; then the gradient divider runs, one quotient bit a cycle,
//   and busy stays high until the quotient is stored. Axis-parallel lines
//   skip the divider and emit nothing on start.
// Advance, axis-parallel line: one pixel the cycle after acceptance, busy
//   never rises, so one advance can be taken every cycle.
// Advance, sloped line: busy through S_STEP alone on the final step (end
//   pixel), and through S_STEP, S_EMIT_LO and S_EMIT_HI on an interior step
//   (minor update, then two pixels); a new word waits until busy is low.
// An advance with no active line gives no pixel. Reset clears the line state
// and the sequencer; no line is active afterwards.
`timescale 1ns / 1ps
`default_nettype none
module antialiased_line_stepper_top #(
	parameter int FRAC_BITS = als_pkg::FRAC_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	output logic                                 busy,
	input  wire                                  cmd,
	input  wire  [als_pkg::COORD_BITS-1:0]       start_x,
	input  wire  [als_pkg::COORD_BITS-1:0]       start_y,
	input  wire  [als_pkg::COORD_BITS-1:0]       end_x,
	input  wire  [als_pkg::COORD_BITS-1:0]       end_y,
	output logic                                 strobe,
	output logic [als_pkg::COORD_BITS-1:0]       pixel_x,
	output logic [als_pkg::COORD_BITS-1:0]       pixel_y,
	output logic [als_pkg::LEVEL_BITS-1:0]       intensity,
	output logic                                 last_pixel
);
	import als_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int FIX_W = COORD_BITS + FRAC_BITS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ORDER,
		S_DIV,
		S_STEP,
		S_EMIT_LO,
		S_EMIT_HI
	} state_t;

	state_t state_q;

	logic              active_q;
	logic              axis_q;
	logic              steep_q;
	logic              dir_q;
	logic [CW-1:0]     major_q;
	logic [CW-1:0]     end_q;
	logic [FIX_W-1:0]  minor_q;
	logic [FRAC_BITS:0] grad_q;
	logic [CW-1:0]     end_minor_q;

	logic [CW-1:0] sx_q, sy_q, ex_q, ey_q, dx_q, dy_q;

	logic                  strobe_q;
	logic [CW-1:0]         px_q, py_q;
	logic [LEVEL_BITS-1:0] lvl_q;
	logic                  last_q;
	logic                  div_go_q;

	div_req_t           div_req;
	logic               div_done;
	logic [FRAC_BITS:0] div_quot;

	// ordering of the endpoints
	logic          is_axis, axis_steep, steep_w, swap_w;
	logic [CW-1:0] a0r, b0r, a1r, b1r, a0, b0, a1, b1;
	logic [CW-1:0] ax_major, ax_end, ax_minor;

	// minor coordinate split and coverage
	logic [CW-1:0]             ip;
	logic [CW-1:0]             ip_next;
	logic [FRAC_BITS-1:0]      frac;
	logic [FRAC_BITS+7:0]      prod;
	logic [LEVEL_BITS-1:0]     cov;
	logic [FIX_W-1:0]          grad_ext;
	logic                      accept;
	logic                      ax_last;

	always_comb begin
		is_axis = (dx_q == '0) || (dy_q == '0);
		axis_steep = (dx_q == '0);
		ax_major = axis_steep ? sy_q : sx_q;
		ax_end = axis_steep ? ey_q : ex_q;
		ax_minor = axis_steep ? sx_q : sy_q;
		steep_w = (dy_q >= dx_q);
		a0r = steep_w ? sy_q : sx_q;
		b0r = steep_w ? sx_q : sy_q;
		a1r = steep_w ? ey_q : ex_q;
		b1r = steep_w ? ex_q : ey_q;
		swap_w = (a1r < a0r);
		a0 = swap_w ? a1r : a0r;
		b0 = swap_w ? b1r : b0r;
		a1 = swap_w ? a0r : a1r;
		b1 = swap_w ? b0r : b1r;
	end

	always_comb begin
		ip = minor_q[FIX_W-1 -: CW];
		ip_next = ip + 1'b1;
		frac = minor_q[FRAC_BITS-1:0];
		prod = {frac, 8'b0} - {8'b0, frac};
		cov = prod[FRAC_BITS+7 -: LEVEL_BITS];
		grad_ext = {{(FIX_W-FRAC_BITS-1){1'b0}}, grad_q};
		accept = start && (state_q == S_IDLE);
		ax_last = (major_q == end_q);
	end

	always_comb begin
		div_req.go = div_go_q;
		div_req.num = steep_q ? dx_q : dy_q;
		div_req.den = steep_q ? dy_q : dx_q;
	end

	als_divider #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk) begin
		if (accept && (cmd == CMD_START)) begin
			sx_q <= start_x;
			sy_q <= start_y;
			ex_q <= end_x;
			ey_q <= end_y;
			dx_q <= (end_x > start_x) ? end_x - start_x : start_x - end_x;
			dy_q <= (end_y > start_y) ? end_y - start_y : start_y - end_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			active_q <= 1'b0;
			axis_q <= 1'b0;
			steep_q <= 1'b0;
			dir_q <= 1'b0;
			major_q <= '0;
			end_q <= '0;
			minor_q <= '0;
			grad_q <= '0;
			end_minor_q <= '0;
			div_go_q <= 1'b0;
			strobe_q <= 1'b0;
			px_q <= '0;
			py_q <= '0;
			lvl_q <= '0;
			last_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			div_go_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd == CMD_START) begin
							state_q <= S_ORDER;
						end else if (active_q && axis_q) begin
							strobe_q <= 1'b1;
							px_q <= steep_q ? end_minor_q : major_q;
							py_q <= steep_q ? major_q : end_minor_q;
							lvl_q <= AXIS_LEVEL;
							last_q <= ax_last;
							if (ax_last) begin
								active_q <= 1'b0;
							end else if (dir_q) begin
								major_q <= major_q - 1'b1;
							end else begin
								major_q <= major_q + 1'b1;
							end
						end else if (active_q) begin
							major_q <= major_q + 1'b1;
							state_q <= S_STEP;
						end
					end
				end
				S_ORDER: begin
					active_q <= 1'b1;
					minor_q <= '0;
					grad_q <= '0;
					if (is_axis) begin
						axis_q <= 1'b1;
						steep_q <= axis_steep;
						major_q <= ax_major;
						end_q <= ax_end;
						end_minor_q <= ax_minor;
						dir_q <= (ax_end < ax_major);
						state_q <= S_IDLE;
					end else begin
						axis_q <= 1'b0;
						steep_q <= steep_w;
						dir_q <= (b1 < b0);
						minor_q <= {b0, {FRAC_BITS{1'b0}}};
						major_q <= a0;
						end_q <= a1;
						end_minor_q <= b1;
						div_go_q <= 1'b1;
						strobe_q <= 1'b1;
						px_q <= steep_w ? b0 : a0;
						py_q <= steep_w ? a0 : b0;
						lvl_q <= FULL_LEVEL;
						last_q <= 1'b0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						grad_q <= div_quot;
						state_q <= S_IDLE;
					end
				end
				S_STEP: begin
					if (major_q == end_q) begin
						strobe_q <= 1'b1;
						px_q <= steep_q ? end_minor_q : end_q;
						py_q <= steep_q ? end_q : end_minor_q;
						lvl_q <= FULL_LEVEL;
						last_q <= 1'b1;
						active_q <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						if (dir_q) begin
							minor_q <= minor_q - grad_ext;
						end else begin
							minor_q <= minor_q + grad_ext;
						end
						state_q <= S_EMIT_LO;
					end
				end
				S_EMIT_LO: begin
					strobe_q <= 1'b1;
					px_q <= steep_q ? ip : major_q;
					py_q <= steep_q ? major_q : ip;
					lvl_q <= FULL_LEVEL - cov;
					last_q <= 1'b0;
					state_q <= S_EMIT_HI;
				end
				S_EMIT_HI: begin
					strobe_q <= 1'b1;
					px_q <= steep_q ? ip_next : major_q;
					py_q <= steep_q ? major_q : ip_next;
					lvl_q <= cov;
					last_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign pixel_x = px_q;
	assign pixel_y = py_q;
	assign intensity = lvl_q;
	assign last_pixel = last_q;

endmodule
`default_nettype wire

// File: design/als_checker.sv
// port-level checks on the line stepper and their binding to the top level
`timescale 1ns / 1ps
`default_nettype none
module als_checker (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire busy,
	input wire cmd,
	input wire strobe,
	input wire last_pixel
);
	import als_pkg::*;

	// a start word always goes through ordering, with no pixel yet
	a_start_orders: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd == CMD_START) |=> busy && !strobe)
		else $error("start word did not enter ordering");

	// the final pixel of a line is never directly followed by another
	a_last_alone: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_pixel |=> !strobe)
		else $error("pixel right after the final pixel");

	// busy only rises after a word was taken
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a word");

endmodule

bind antialiased_line_stepper_top als_checker u_als_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.cmd        (cmd),
	.strobe     (strobe),
	.last_pixel (last_pixel)
);
`default_nettype wire
